### design/conductivity_temp_compensation_macros.svh
// ---------------------------------------------------------------------------
// Conductivity temperature compensation - assertion macros
// Shared concurrent assertion forms, clocked on clock and idle during reset.
// ---------------------------------------------------------------------------
`ifndef CONDUCTIVITY_TEMP_COMPENSATION_MACROS_SVH
`define CONDUCTIVITY_TEMP_COMPENSATION_MACROS_SVH

// Check a plain property on every clock edge outside reset.
`define CTC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define CTC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### design/ctc_pkg.sv
// ---------------------------------------------------------------------------
// Conductivity temperature compensation - package
// Shared types, register codes and fixed-point constants.
// ---------------------------------------------------------------------------
package ctc_pkg;

   localparam int ADC_W   = 10;
   localparam int TEMP_W  = 16;
   localparam int EC_W    = 24;
   localparam int DIVS_W  = 32;   // signed compensation divisor
   localparam int DIV_W   = 31;   // magnitude of a positive divisor
   localparam int NUM_W   = 45;   // ec * COMP_SCALE
   localparam int SCALE_W = 21;
   localparam int Q_DEPTH = 2;

   localparam logic [EC_W-1:0]    EC_MAX     = 24'hFF_FFFF;
   localparam logic [SCALE_W-1:0] COMP_SCALE = 21'd1600000;

   localparam logic [15:0] VPC_RESET  = 16'd320;
   localparam logic [15:0] CELL_RESET = 16'd256;
   localparam logic [13:0] COEF_RESET = 14'd900;
   localparam logic [11:0] TREF_RESET = 12'd400;

   typedef enum logic [1:0] {
      CSR_VOLTS = 2'd0,
      CSR_CELL  = 2'd1,
      CSR_COEF  = 2'd2,
      CSR_TREF  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NEG      = 2'd1,
      ST_ZERO_DIV = 2'd2
   } comp_status_type;

   typedef struct packed {
      logic [15:0]        volts_per_count;
      logic [15:0]        cell_constant;
      logic [13:0]        temp_coefficient;
      logic signed [11:0] reference_temp;
   } cfg_type;

   typedef struct packed {
      logic [TEMP_W-1:0]        temp;
      logic [EC_W-1:0]          ec;
      logic signed [DIVS_W-1:0] divisor;
   } item_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_SUM,
      F_AVG,
      F_GAIN,
      F_CELL,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_CLASS,
      B_CHECK,
      B_DIV,
      B_OUT
   } back_state_type;

endpackage

### design/ctc_front.sv
// ---------------------------------------------------------------------------
// Conductivity temperature compensation - front end
// Sample ring and running sum, boxcar mean, EC scaling and divisor build.
// ---------------------------------------------------------------------------
module ctc_front import ctc_pkg::*; #(
   parameter int WINDOW = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [ADC_W-1:0]  adc_sample,
   input  logic [TEMP_W-1:0] temp_raw,
   output logic              push,
   output item_type          push_item,
   input  logic              q_full
);

   localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W   = $clog2(WINDOW * 1023 + 1);
   localparam int SHIFT   = $clog2(WINDOW);
   localparam int RECIP_I = ((1 << (SUM_W + SHIFT)) + WINDOW - 1) / WINDOW;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = 2 * SUM_W + 1;
   localparam int AVG_LSB = SUM_W + SHIFT;
   localparam int GAIN_W  = ADC_W + 16;
   localparam int CELL_W  = GAIN_W + 16;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_I);
   localparam logic [POS_W-1:0]   LAST  = POS_W'(WINDOW - 1);

   front_state_type          state_ff, state_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [WINDOW-1:0]        valid_ff, valid_in;

   logic [ADC_W-1:0]         ring [WINDOW];
   logic [ADC_W-1:0]         old_ff;
   logic [ADC_W-1:0]         sample_ff, sample_in;
   logic [TEMP_W-1:0]        temp_ff, temp_in;
   logic [PROD_W-1:0]        recip_ff, recip_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic [CELL_W-1:0]        cell_ff, cell_in;
   logic signed [DIVS_W-1:0] tprod_ff, tprod_in;

   logic                     accept;
   logic signed [16:0]       tdiff;
   logic [ADC_W-1:0]         avg;

   assign in_ready = (state_ff == F_IDLE);
   assign accept   = in_valid && in_ready;
   assign tdiff    = $signed({temp_ff[TEMP_W-1], temp_ff})
                   - $signed({{5{cfg.reference_temp[11]}}, cfg.reference_temp});
   assign avg      = recip_ff[AVG_LSB +: ADC_W];

   // Result record toward the queue.
   assign push_item.temp    = temp_ff;
   assign push_item.ec      = (cell_ff[CELL_W-1:EC_W+8] != '0) ? EC_MAX : cell_ff[EC_W+7:8];
   assign push_item.divisor = $signed(DIVS_W'(COMP_SCALE)) + tprod_ff;

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      valid_in  = valid_ff;
      sample_in = sample_ff;
      temp_in   = temp_ff;
      recip_in  = recip_ff;
      gain_in   = gain_ff;
      cell_in   = cell_ff;
      tprod_in  = tprod_ff;
      push      = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               sample_in        = adc_sample;
               temp_in          = {temp_raw[TEMP_W-1:1], 1'b0};
               valid_in[pos_ff] = 1'b1;
               pos_in           = (pos_ff == LAST) ? '0 : pos_ff + 1'b1;
               state_in         = F_SUM;
            end
         end
         F_SUM: begin
            // drop the oldest sample, add the new one
            sum_in   = sum_ff - SUM_W'(old_ff) + SUM_W'(sample_ff);
            tprod_in = DIVS_W'($signed({1'b0, cfg.temp_coefficient}))
                     * DIVS_W'(tdiff);
            state_in = F_AVG;
         end
         F_AVG: begin
            // mean by reciprocal multiply, exact over the whole sum range
            recip_in = PROD_W'(sum_ff) * PROD_W'(RECIP);
            state_in = F_GAIN;
         end
         F_GAIN: begin
            gain_in  = GAIN_W'(avg) * GAIN_W'(cfg.volts_per_count);
            state_in = F_CELL;
         end
         F_CELL: begin
            cell_in  = CELL_W'(gain_ff) * CELL_W'(cfg.cell_constant);
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         pos_ff   <= '0;
         sum_ff   <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      temp_ff   <= temp_in;
      recip_ff  <= recip_in;
      gain_ff   <= gain_in;
      cell_ff   <= cell_in;
      tprod_ff  <= tprod_in;
   end

   // Ring memory: read the slot being replaced, write the new sample.
   always_ff @(posedge clock) begin
      if (accept) begin
         old_ff       <= valid_ff[pos_ff] ? ring[pos_ff] : '0;
         ring[pos_ff] <= adc_sample;
      end
   end

endmodule

### design/ctc_queue.sv
// ---------------------------------------------------------------------------
// Conductivity temperature compensation - item queue
// Two-entry queue between the front end and the divider back end.
// ---------------------------------------------------------------------------
module ctc_queue import ctc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int PTR_W = $clog2(Q_DEPTH);
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   item_type          mem [Q_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(Q_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem[rd_ff];

   always_comb begin
      wr_in  = do_push ? PTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? PTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_item;
      end
   end

endmodule

### design/ctc_back.sv
// ---------------------------------------------------------------------------
// Conductivity temperature compensation - back end
// Classify the divisor, run the restoring divider, hold the result word.
// ---------------------------------------------------------------------------
module ctc_back import ctc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  item_type             q_item,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [TEMP_W-1:0]    out_temp,
   output logic [EC_W-1:0]      out_ec,
   output logic [EC_W-1:0]      out_comp,
   output comp_status_type      out_status
);

   `include "conductivity_temp_compensation_macros.svh"

   localparam int CNT_W = $clog2(EC_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(EC_W - 1);

   back_state_type    state_ff, state_in;
   item_type          item_ff, item_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [EC_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [EC_W-1:0]   comp_ff, comp_in;
   comp_status_type   status_ff, status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic [EC_W-1:0]   rsp_ec_ff, rsp_ec_in;
   logic [EC_W-1:0]   rsp_comp_ff, rsp_comp_in;
   comp_status_type   rsp_status_ff, rsp_status_in;

   logic [DIV_W-1:0]  div_mag;
   logic [DIV_W:0]    trial;
   logic              fits;
   logic              out_free;

   assign div_mag  = item_ff.divisor[DIV_W-1:0];
   assign trial    = {rem_ff, quo_ff[EC_W-1]};
   assign fits     = (trial >= {1'b0, div_mag});
   assign out_free = !rsp_valid_ff || out_ready;

   assign out_valid  = rsp_valid_ff;
   assign out_temp   = rsp_temp_ff;
   assign out_ec     = rsp_ec_ff;
   assign out_comp   = rsp_comp_ff;
   assign out_status = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      comp_in       = comp_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !out_ready;
      rsp_temp_in   = rsp_temp_ff;
      rsp_ec_in     = rsp_ec_ff;
      rsp_comp_in   = rsp_comp_ff;
      rsp_status_in = rsp_status_ff;
      pop           = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               item_in  = q_item;
               state_in = B_CLASS;
            end
         end
         B_CLASS: begin
            num_in = NUM_W'(item_ff.ec) * NUM_W'(COMP_SCALE);
            if (item_ff.divisor == '0) begin
               comp_in   = EC_MAX;
               status_in = ST_ZERO_DIV;
               state_in  = B_OUT;
            end else if (item_ff.divisor < 0) begin
               comp_in   = '0;
               status_in = (item_ff.ec != '0) ? ST_NEG : ST_OK;
               state_in  = B_OUT;
            end else begin
               status_in = ST_OK;
               state_in  = B_CHECK;
            end
         end
         B_CHECK: begin
            // quotient overflows 24 bits when num >= divisor * 2^24
            if (DIV_W'(num_ff[NUM_W-1:EC_W]) >= div_mag) begin
               comp_in  = EC_MAX;
               state_in = B_OUT;
            end else begin
               rem_in   = DIV_W'(num_ff[NUM_W-1:EC_W]);
               quo_in   = num_ff[EC_W-1:0];
               cnt_in   = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            // one quotient bit per cycle, dividend bits shift out of quo
            rem_in = fits ? DIV_W'(trial - {1'b0, div_mag}) : trial[DIV_W-1:0];
            quo_in = {quo_ff[EC_W-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               comp_in  = {quo_ff[EC_W-2:0], fits};
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_temp_in   = item_ff.temp;
               rsp_ec_in     = item_ff.ec;
               rsp_comp_in   = comp_ff;
               rsp_status_in = status_ff;
               state_in      = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      comp_ff       <= comp_in;
      status_ff     <= status_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_ec_ff     <= rsp_ec_in;
      rsp_comp_ff   <= rsp_comp_in;
      rsp_status_ff <= rsp_status_in;
   end

   `CTC_ASSERT(a_zero_div_saturates, !(rsp_valid_ff && rsp_status_ff == ST_ZERO_DIV) || rsp_comp_ff == EC_MAX, "zero divisor result not saturated")
   `CTC_ASSERT_IMPL(a_negative_is_zero, rsp_valid_ff && rsp_status_ff == ST_NEG, rsp_comp_ff == '0, "negative result not forced to zero")
   `CTC_ASSERT_IMPL(a_rem_below_divisor, state_ff == B_DIV, rem_ff < div_mag, "divider remainder reached divisor")

endmodule

### design/conductivity_temp_compensation.sv
// ---------------------------------------------------------------------------
// Conductivity temperature compensation - top level
// Boxcar-averaged conductivity with linear temperature compensation.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one word per sensor reading (conductance ADC sample and raw
//   thermometer value). rsp channel: one word per reading with temperature,
//   measured EC, compensated EC and a status code. csr port: plain writes of
//   the four calibration registers, to be done by the user only while the
//   block is idle; the block itself does not enforce it. The front end takes
//   a new reading only after it has pushed the last one; the back end takes
//   an item only when idle and runs a 24-step restoring divider, which zero
//   or negative divisors and saturating quotients skip.
//   The two-entry queue lets the front end run ahead of the divider.
//   Reset: clears the sample ring (by valid bits), running sum, position,
//   the queue and the result register, and reloads the register defaults.
//   Receiver stall: the result word holds in the output register, the
//   divider waits, the queue fills, and req_tready stays low while the
//   front end has a finished word it cannot push.
// ---------------------------------------------------------------------------
module conductivity_temp_compensation import ctc_pkg::*; #(
   parameter int WINDOW = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [9:0] adc_sample, [25:10] temp_raw
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // [15:0] temp_sixteenths, [39:16] ec_value,
                                     // [63:40] ec_compensated, [65:64] comp_status
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   cfg_type           cfg_ff, cfg_in;
   logic              push, q_full, q_empty, pop;
   item_type          push_item, q_item;
   logic [TEMP_W-1:0] out_temp;
   logic [EC_W-1:0]   out_ec, out_comp;
   comp_status_type   out_status;

   // Register writes, decoded by index.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_VOLTS: cfg_in.volts_per_count  = csr_wdata;
            CSR_CELL:  cfg_in.cell_constant    = csr_wdata;
            CSR_COEF:  cfg_in.temp_coefficient = csr_wdata[13:0];
            CSR_TREF:  cfg_in.reference_temp   = $signed(csr_wdata[11:0]);
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volts_per_count  <= VPC_RESET;
         cfg_ff.cell_constant    <= CELL_RESET;
         cfg_ff.temp_coefficient <= COEF_RESET;
         cfg_ff.reference_temp   <= $signed(TREF_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: ring, mean, EC and divisor.
   ctc_front #(
      .WINDOW(WINDOW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .adc_sample (req_tdata[9:0]),
      .temp_raw   (req_tdata[25:10]),
      .push       (push),
      .push_item  (push_item),
      .q_full     (q_full)
   );

   // Decouple the front end from the divider.
   ctc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   // Back end: classify, divide, hold the result word.
   ctc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_item     (q_item),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_temp   (out_temp),
      .out_ec     (out_ec),
      .out_comp   (out_comp),
      .out_status (out_status)
   );

   // Pack the result word, zero fill to whole bytes.
   assign rsp_tdata = {6'b0, out_status, out_comp, out_ec, out_temp};

endmodule

### tb/ec_reading_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Conductivity compensation checker
// Watches the req, rsp and csr ports. Predicts each result word from its
// own copy of the sample ring and the calibration registers, then checks
// every result word, field by field, against the oldest prediction.
// ---------------------------------------------------------------------------
module ec_reading_checker import ctc_pkg::*; #(
   parameter int WINDOW = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output int          mismatches,
   output int          outstanding
);

   localparam longint SCALE = 1600000;

   typedef struct packed {
      logic [15:0]     temp;
      logic [23:0]     ec;
      logic [23:0]     comp;
      comp_status_type status;
   } reading_type;

   logic [9:0]         ring [WINDOW];
   int                 window_total;
   int                 slot;
   logic [15:0]        gain;
   logic [15:0]        cell_const;
   logic [13:0]        coef;
   logic signed [11:0] ref_temp;
   reading_type        readings_due [$];
   int                 errors;

   // Advance the ring by one sample and work out the result word it causes.
   function automatic reading_type compensate_reading(input logic [9:0] adc,
                                                      input logic [15:0] temp_raw);
      reading_type     r;
      longint unsigned mean;
      longint unsigned ec_full;
      longint unsigned comp_full;
      longint          divisor;
      window_total = window_total - ring[slot] + adc;
      ring[slot] = adc;
      slot = (slot == WINDOW - 1) ? 0 : slot + 1;
      mean = 64'(window_total / WINDOW);
      ec_full = (mean * gain * cell_const) >> 8;
      if (ec_full > EC_MAX)
         ec_full = 64'(EC_MAX);
      r.temp = {temp_raw[15:1], 1'b0};
      r.ec = ec_full[23:0];
      divisor = SCALE + longint'(coef) * (longint'($signed(r.temp)) - longint'(ref_temp));
      if (divisor == 0) begin
         r.comp = EC_MAX;
         r.status = ST_ZERO_DIV;
      end else if (divisor < 0) begin
         r.comp = '0;
         r.status = (ec_full != 0) ? ST_NEG : ST_OK;
      end else begin
         comp_full = (ec_full * 1600000) / $unsigned(divisor);
         if (comp_full > EC_MAX)
            comp_full = 64'(EC_MAX);
         r.comp = comp_full[23:0];
         r.status = ST_OK;
      end
      return r;
   endfunction

   task automatic flag_field(input string name, input logic [23:0] want,
                             input logic [23:0] seen);
      if (seen !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
      end
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         foreach (ring[i])
            ring[i] = '0;
         window_total = 0;
         slot = 0;
         gain = VPC_RESET;
         cell_const = CELL_RESET;
         coef = COEF_RESET;
         ref_temp = TREF_RESET;
         readings_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_VOLTS: gain = csr_wdata;
               CSR_CELL:  cell_const = csr_wdata;
               CSR_COEF:  coef = csr_wdata[13:0];
               CSR_TREF:  ref_temp = csr_wdata[11:0];
            endcase
         end
         if (req_tvalid && req_tready)
            readings_due.push_back(compensate_reading(req_tdata[9:0], req_tdata[25:10]));
         if (rsp_tvalid && rsp_tready) begin
            if (readings_due.size() == 0) begin
               errors++;
               $display("%0t: result word with none expected, expected nothing, got %h",
                        $time, rsp_tdata);
            end else begin
               want = readings_due.pop_front();
               flag_field("temp_sixteenths", {8'b0, want.temp}, {8'b0, rsp_tdata[15:0]});
               flag_field("ec_value", want.ec, rsp_tdata[39:16]);
               flag_field("ec_compensated", want.comp, rsp_tdata[63:40]);
               flag_field("comp_status", {22'b0, want.status}, {22'b0, rsp_tdata[65:64]});
            end
         end
      end
      mismatches <= errors;
      outstanding <= readings_due.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Conductivity compensation testbench
// Drives sensor reading words and calibration writes into the block, with
// random idling on both channels, and leaves all checking to the checker
// that sits beside the block. Gives the verdict at the end.
// ---------------------------------------------------------------------------
module tb_top;
   import ctc_pkg::*;

   localparam int WINDOW      = 10;
   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 250;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [9:0] adc_sample, [25:10] temp_raw
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // [15:0] temp_sixteenths, [39:16] ec_value,
                              // [63:40] ec_compensated, [65:64] comp_status
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;

   int mismatches;
   int outstanding;

   // Set for the final phase: no idling on either side from then on.
   bit calm;
   // Current coefficient and reference, kept only to aim temperatures.
   int cur_coef;
   int cur_tref;
   // Slowly wandering conductance level so the boxcar average settles.
   int level;

   always #10 clock = ~clock;

   conductivity_temp_compensation #(.WINDOW(WINDOW)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   ec_reading_checker #(.WINDOW(WINDOW)) reading_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Hold one register write for a single edge; the caller drops csr_we.
   task automatic put_reg(input csr_index_type idx, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write all four calibration registers. Call only with the block idle.
   task automatic load_settings(input logic [15:0] vpc, input logic [15:0] cell_const,
                                input logic [13:0] coef, input logic [11:0] tref);
      put_reg(CSR_VOLTS, vpc);
      put_reg(CSR_CELL, cell_const);
      put_reg(CSR_COEF, {2'b0, coef});
      put_reg(CSR_TREF, {4'b0, tref});
      csr_we <= 1'b0;
      cur_coef = int'(coef);
      cur_tref = int'($signed(tref));
   endtask

   // Pick a random calibration: plausible values, or anything the widths allow.
   task automatic pick_settings(input bit full);
      int          divisors [7] = '{500, 640, 800, 1000, 2000, 6400, 10000};
      logic [15:0] vpc;
      logic [15:0] cell_const;
      logic [13:0] coef;
      logic [11:0] tref;
      if (full) begin
         vpc = 16'($urandom);
         cell_const = 16'($urandom);
         coef = 14'($urandom_range(0, 16383));
         tref = 12'($urandom);
      end else begin
         vpc = 16'($urandom_range(200, 400));
         cell_const = 16'($urandom_range(64, 1024));
         coef = 14'($urandom_range(0, 10000));
         tref = 12'($urandom_range(0, 2880) - 880);
      end
      // a coefficient that divides the scale lets the divisor hit zero exactly
      if ($urandom_range(0, 2) == 0)
         coef = 14'(divisors[$urandom_range(0, 6)]);
      load_settings(vpc, cell_const, coef, tref);
   endtask

   // Offer one reading word, after an optional idle burst, and hold it until
   // it is taken. tvalid stays high for back-to-back words.
   task automatic send_word(input logic [9:0] adc, input logic [15:0] temp_raw);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, temp_raw, adc};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop tvalid and wait until every result word has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [9:0] random_adc();
      if ($urandom_range(0, 49) == 0)
         level = $urandom_range(0, 1023);
      if ($urandom_range(0, 1) == 0)
         return 10'($urandom);
      return 10'(level + $urandom_range(0, 20) - 10);
   endfunction

   // Mostly temperatures around the reference, some anywhere, and now and
   // then the one temperature that makes the divisor zero.
   function automatic logic [15:0] random_temp();
      int pick;
      int t;
      pick = $urandom_range(0, 99);
      if (pick < 4 && cur_coef != 0 && (1600000 % cur_coef) == 0) begin
         t = cur_tref - 1600000 / cur_coef;
         if (t >= -32768 && t % 2 == 0)
            return 16'(t) | 16'($urandom_range(0, 1));
      end
      if (pick < 30)
         return 16'($urandom);
      t = cur_tref + $urandom_range(0, 1600) - 800;
      return 16'(t);
   endfunction

   // Receiver side: random stall bursts until the final phase.
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && !reset && $urandom_range(0, 11) == 0) begin
            stall = $urandom_range(1, 17);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_addr <= CSR_VOLTS;
      csr_wdata <= '0;
      calm = 1'b0;
      cur_coef = 900;
      cur_tref = 400;
      level = 512;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset calibration. The ring is still clear, so the first word has
      // zero EC; with the coldest temperature the divisor goes negative.
      send_word(10'd0, 16'h8001);
      send_word(10'd1023, 16'h7FFF);
      // negative divisor, nonzero EC: forced to zero and flagged
      send_word(10'd1023, 16'h8000);
      send_word(10'd512, 16'd401);
      drain();

      // Full gain and cell constant saturate EC. With a coefficient of 1000
      // and the reference at 25 C, -1200 zeroes the divisor, -1198 leaves a
      // tiny divisor that overflows, -1202 turns it negative.
      load_settings(16'hFFFF, 16'hFFFF, 14'd1000, 12'd400);
      send_word(10'd1023, 16'(-1200));
      send_word(10'd1023, 16'(-1199));
      send_word(10'd700, 16'(-1198));
      send_word(10'd1, 16'(-1202));
      send_word(10'd300, 16'd400);
      drain();

      // Zero gain, widest coefficient, most negative reference.
      load_settings(16'h0000, 16'h0000, 14'h3FFF, 12'h800);
      send_word(10'd1023, 16'h8000);
      send_word(10'd0, 16'h7FFF);
      send_word(10'd5, 16'h0000);
      drain();

      // Zero coefficient: compensation passes EC through unchanged.
      load_settings(VPC_RESET, CELL_RESET, 14'd0, 12'h7FF);
      send_word(10'd1023, 16'h0000);
      send_word(10'd0, 16'hFFFF);
      send_word(10'd1023, 16'h5555);
      send_word(10'd0, 16'hAAAA);
      drain();

      // Random phases, alternating plausible and full-width calibration.
      for (int p = 0; p < PHASES; p++) begin
         pick_settings(1'(p % 2));
         if (p == PHASES - 1)
            calm = 1'b1;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // now and then let the pipeline run dry mid-phase
            if (!calm && $urandom_range(0, 199) == 0)
               drain();
            send_word(random_adc(), random_temp());
         end
         drain();
      end

      // Tail: catch any stray word the block might still push out.
      repeat (60) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
